/* hw/rtl/elps_pkg.sv */
// elps_pkg: shared types, codes and constants of the event-list pwm scheduler
// used by every module under hw/rtl; depends on nothing
package elps_pkg;

  localparam int MAX_EVENTS_DEF    = 20;
  localparam int US_PER_TICK_DEF   = 16;
  localparam int NPINS             = 31;
  localparam int PIN_W             = 5;
  localparam int TIME_W            = 11;
  localparam int ENTRY_W           = 16;
  localparam int DUTY_W            = 11;
  localparam int VAL_W             = 10;
  localparam int US_W              = 20;
  localparam int TICK_W            = 16;
  localparam int TNOW_W            = 17;
  localparam int ALU_W             = 18;
  localparam int PROD_SHIFT        = 10;
  localparam int END_TIME          = 1024;
  localparam int DUTY_MAX          = (1 << 10) - 1;
  localparam int PERIOD_US_MIN     = 256;
  localparam int PERIOD_US_MAX     = 1000000;
  localparam int DEFAULT_PERIOD_US = 20 * 1000;

  localparam logic [PIN_W-1:0] END_PIN = PIN_W'(31);

  typedef logic [ENTRY_W-1:0] entry_t;

  // end-of-period entry: clears the pwm pins of the active table and restarts the period
  localparam entry_t END_ENTRY = {END_PIN, TIME_W'(END_TIME)};

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_DUTY    = 2'd1,
    ACT_PERIOD  = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    action_t            action;
    logic [PIN_W-1:0]   pin;
    logic [DUTY_W-1:0]  duty;
    logic [US_W-1:0]    period_us;
  } in_item_t;

  typedef struct packed {
    logic [NPINS-1:0]  pin_levels;
    logic [NPINS-1:0]  output_enables;
    logic [TICK_W-1:0] next_delay;
    logic [TICK_W-1:0] period_ticks;
    status_t           status;
  } out_item_t;

  function automatic logic [TIME_W-1:0] entry_time(input entry_t e);
    return e[TIME_W-1:0];
  endfunction

  function automatic logic [PIN_W-1:0] entry_pin(input entry_t e);
    return e[ENTRY_W-1:TIME_W];
  endfunction

endpackage

/* hw/rtl/elps_table.sv */
// elps_table: the two event table buffers, one read and one write port
// depends on elps_pkg
module elps_table #(
  parameter int MAX_EVENTS = elps_pkg::MAX_EVENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_sel,
  input  logic [$clog2(MAX_EVENTS)-1:0] rd_idx,
  output elps_pkg::entry_t              rd_data,
  input  logic                          wr_en,
  input  logic                          wr_sel,
  input  logic [$clog2(MAX_EVENTS)-1:0] wr_idx,
  input  elps_pkg::entry_t              wr_data
);
  import elps_pkg::*;

  entry_t tab_a_r [MAX_EVENTS];
  entry_t tab_b_r [MAX_EVENTS];

  // buffer b when sel is high
  assign rd_data = rd_sel ? tab_b_r[rd_idx] : tab_a_r[rd_idx];

  // only entry 0 is ever read before it is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_a_r[0] <= END_ENTRY;
      tab_b_r[0] <= END_ENTRY;
    end else if (wr_en) begin
      if (wr_sel) begin
        tab_b_r[wr_idx] <= wr_data;
      end else begin
        tab_a_r[wr_idx] <= wr_data;
      end
    end
  end

endmodule

/* hw/rtl/elps_alu.sv */
// elps_alu: shared arithmetic unit, scaled multiply and subtract
// depends on elps_pkg
module elps_alu (
  input  elps_pkg::alu_op_t                 op,
  input  logic [elps_pkg::ALU_W-1:0]        a,
  input  logic [elps_pkg::ALU_W-1:0]        b,
  output logic signed [elps_pkg::ALU_W:0]   res
);
  import elps_pkg::*;

  logic [TIME_W+TICK_W-1:0] prod;

  assign prod = a[TIME_W-1:0] * b[TICK_W-1:0];

  always_comb begin
    unique case (op)
      ALU_MUL: res = signed'((ALU_W+1)'(prod >> PROD_SHIFT));
      ALU_SUB: res = signed'({1'b0, a}) - signed'({1'b0, b});
      default: res = '0;
    endcase
  end

endmodule

/* hw/rtl/event_list_pwm_scheduler_unit.sv */
// event_list_pwm_scheduler_unit: top level, sequencer over the event tables
// depends on elps_pkg, elps_table, elps_alu
//
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------
//  input   | in_valid, in_stall, in_data    | elps_pkg::in_item_t
//  result  | out_valid, out_stall, out_data | elps_pkg::out_item_t
//
// one item at a time; in_stall is high from a transfer until its result is
// loaded into the output register, which may still wait while a new item runs.
// tick: fires due events, chaining through those with zero delay, at most 2*MAX_EVENTS+2 per tick.
// set duty / release: copy, search, bubble and release scan steps over the n
// table entries; set period takes its quotient from a constant reciprocal
// multiply, plus the copy when the pending side is stale.
// reset is synchronous; only entry 0 of each table is initialized, no sweep.
module event_list_pwm_scheduler_unit #(
  parameter int MAX_EVENTS  = elps_pkg::MAX_EVENTS_DEF,
  parameter int US_PER_TICK = elps_pkg::US_PER_TICK_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  elps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output elps_pkg::out_item_t out_data
);
  import elps_pkg::*;

  localparam int IDX_W    = $clog2(MAX_EVENTS);
  localparam int CNT_W    = $clog2(MAX_EVENTS + 1);
  localparam int ITER_MAX = 2 * MAX_EVENTS + 2;
  localparam int ITER_W   = $clog2(ITER_MAX + 1);
  // reciprocal shift: dividend bits plus log2 of the largest divisor plus one
  localparam int RCP_SH   = US_W + 7;
  localparam logic [RCP_SH:0] RECIP =
    (RCP_SH+1)'(((64'd1 << RCP_SH) + 64'(US_PER_TICK) - 64'd1) / 64'(US_PER_TICK));
  localparam logic [TICK_W-1:0] DEFAULT_TICKS = TICK_W'(DEFAULT_PERIOD_US / US_PER_TICK);

  typedef enum logic [4:0] {
    S_IDLE, S_TP, S_CP, S_PSET, S_FIND, S_RMV, S_BUBL, S_BUBR,
    S_SDEND, S_REL, S_TK0, S_TK1, S_TKP, S_TKR, S_TKM, S_TKC, S_DONE
  } state_t;

  state_t              state_r;
  action_t             act_code_r;
  status_t             status_r;
  logic [PIN_W-1:0]    pin_r;
  logic [VAL_W-1:0]    val_r;
  logic [US_W-1:0]     us_r;
  logic [CNT_W-1:0]    cnt_r [2];
  logic [TICK_W-1:0]   per_r [2];
  logic [NPINS-1:0]    pins_r [2];
  logic                act_r;
  logic                pv_r;
  logic [CNT_W-1:0]    nidx_r;
  logic [NPINS-1:0]    lvl_r;
  logic [NPINS-1:0]    en_r;
  logic [CNT_W-1:0]    i_r;
  logic [CNT_W-1:0]    p_r;
  logic                moved_r;
  entry_t              x_r;
  entry_t              cur_r;
  logic [TNOW_W-1:0]   tnow_r;
  logic [TNOW_W-1:0]   prod_r;
  logic [ITER_W-1:0]   iter_r;
  logic [TICK_W-1:0]   delay_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                  rd_sel;
  logic [IDX_W-1:0]      rd_idx;
  entry_t                rd_data;
  logic                  wr_en;
  logic                  wr_sel;
  logic [IDX_W-1:0]      wr_idx;
  entry_t                wr_data;
  alu_op_t               alu_op;
  logic [ALU_W-1:0]      alu_a;
  logic [ALU_W-1:0]      alu_b;
  logic signed [ALU_W:0] alu_res;

  logic [CNT_W-1:0]  cnt_act;
  logic [CNT_W-1:0]  cnt_dst;
  logic [TICK_W-1:0] per_act;
  logic [NPINS-1:0]  pin_bit;
  entry_t            entry_new;
  entry_t            ev_word;
  logic [CNT_W-1:0]  p_dec;
  logic [CNT_W-1:0]  p_inc;
  logic              bubl_move;
  logic              bubr_move;
  logic              rd_pin_hit;
  logic [US_W+RCP_SH:0] q_prod;
  logic [US_W-1:0]   q_full;
  logic [TICK_W-1:0] q_sat;
  state_t            after_tp;

  elps_table #(.MAX_EVENTS(MAX_EVENTS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_sel  (rd_sel),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_sel  (wr_sel),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  elps_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // views of the active and pending buffers
  assign cnt_act    = cnt_r[act_r];
  assign cnt_dst    = cnt_r[~act_r];
  assign per_act    = per_r[act_r];
  assign pin_bit    = NPINS'(1) << pin_r;
  assign entry_new  = {pin_r, TIME_W'(END_TIME) - TIME_W'(val_r)};
  assign ev_word    = (nidx_r < cnt_act) ? rd_data : END_ENTRY;
  assign p_dec      = p_r - 1'b1;
  assign p_inc      = p_r + 1'b1;
  assign bubl_move  = (p_r != '0) && (entry_time(rd_data) > entry_time(x_r));
  assign bubr_move  = (p_inc < cnt_dst) && (entry_time(rd_data) < entry_time(x_r));
  assign rd_pin_hit = (entry_pin(rd_data) == pin_r);
  assign after_tp   = (act_code_r == ACT_PERIOD) ? S_PSET : S_FIND;

  // period in ticks by reciprocal multiply, exact over the whole input range
  assign q_prod = us_r * RECIP;
  assign q_full = q_prod[RCP_SH+US_W-1:RCP_SH];
  assign q_sat  = (|q_full[US_W-1:TICK_W]) ? '1 : q_full[TICK_W-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // table port and alu operand selection
  always_comb begin
    rd_sel  = act_r;
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_sel  = ~act_r;
    wr_idx  = p_r[IDX_W-1:0];
    wr_data = x_r;
    alu_op  = ALU_SUB;
    alu_a   = '0;
    alu_b   = '0;
    unique case (state_r)
      S_CP: begin
        rd_idx  = i_r[IDX_W-1:0];
        wr_en   = (i_r != cnt_dst);
        wr_idx  = i_r[IDX_W-1:0];
        wr_data = rd_data;
      end
      S_FIND: begin
        rd_sel  = ~act_r;
        rd_idx  = i_r[IDX_W-1:0];
        wr_data = entry_new;
        if (i_r == cnt_dst) begin
          wr_en  = (val_r != '0) && (cnt_dst < CNT_W'(MAX_EVENTS));
          wr_idx = cnt_dst[IDX_W-1:0];
        end else begin
          wr_en  = rd_pin_hit && (val_r != '0);
          wr_idx = i_r[IDX_W-1:0];
        end
      end
      S_RMV: begin
        rd_sel  = ~act_r;
        rd_idx  = cnt_dst[IDX_W-1:0];
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_BUBL: begin
        rd_sel  = ~act_r;
        rd_idx  = p_dec[IDX_W-1:0];
        wr_en   = 1'b1;
        wr_data = bubl_move ? rd_data : x_r;
      end
      S_BUBR: begin
        rd_sel  = ~act_r;
        rd_idx  = p_inc[IDX_W-1:0];
        wr_en   = 1'b1;
        wr_data = bubr_move ? rd_data : x_r;
      end
      S_REL: begin
        rd_idx  = i_r[IDX_W-1:0];
        wr_en   = (i_r != cnt_act) && rd_pin_hit;
        wr_sel  = act_r;
        wr_idx  = i_r[IDX_W-1:0];
        wr_data = {END_PIN, entry_time(rd_data)};
      end
      S_TK0, S_TKR: begin
        rd_idx = nidx_r[IDX_W-1:0];
      end
      S_TK1, S_TKM: begin
        alu_op = ALU_MUL;
        alu_a  = ALU_W'(entry_time(cur_r));
        alu_b  = ALU_W'(per_act);
      end
      S_TKC: begin
        alu_a = ALU_W'(prod_r);
        alu_b = ALU_W'(tnow_r);
      end
      default: begin
      end
    endcase
  end

  // sequencer, buffer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r[0]    <= CNT_W'(1);
      cnt_r[1]    <= CNT_W'(1);
      per_r[0]    <= DEFAULT_TICKS;
      per_r[1]    <= DEFAULT_TICKS;
      pins_r[0]   <= '0;
      pins_r[1]   <= '0;
      act_r       <= 1'b1;
      pv_r        <= 1'b0;
      nidx_r      <= '0;
      lvl_r       <= '0;
      en_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_code_r <= in_data.action;
            pin_r      <= in_data.pin;
            us_r       <= in_data.period_us;
            status_r   <= STAT_OK;
            delay_r    <= '0;
            i_r        <= '0;
            moved_r    <= 1'b0;
            if (in_data.action == ACT_RELEASE) begin
              val_r <= '0;
            end else if (in_data.duty > DUTY_W'(DUTY_MAX)) begin
              val_r <= VAL_W'(DUTY_MAX);
            end else begin
              val_r <= in_data.duty[VAL_W-1:0];
            end
            unique case (in_data.action) inside
              ACT_TICK: state_r <= S_TK0;
              ACT_DUTY, ACT_RELEASE: begin
                state_r <= (in_data.pin == END_PIN) ? S_DONE : S_TP;
              end
              ACT_PERIOD: begin
                if (in_data.period_us < US_W'(PERIOD_US_MIN) ||
                    in_data.period_us > US_W'(PERIOD_US_MAX)) begin
                  status_r <= STAT_RANGE;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_TP;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        // make the pending buffer a copy of the active one if needed
        S_TP: begin
          i_r <= '0;
          if (act_code_r != ACT_PERIOD) begin
            en_r <= en_r | pin_bit;
          end
          if (!pv_r) begin
            cnt_r[~act_r]  <= cnt_act;
            per_r[~act_r]  <= per_act;
            pins_r[~act_r] <= pins_r[act_r];
            state_r        <= S_CP;
          end else begin
            state_r <= after_tp;
          end
        end
        S_CP: begin
          if (i_r == cnt_dst) begin
            i_r     <= '0;
            state_r <= after_tp;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_PSET: begin
          per_r[~act_r] <= q_sat;
          pv_r          <= 1'b1;
          state_r       <= S_DONE;
        end
        // search the pending table for the pin
        S_FIND: begin
          if (i_r == cnt_dst) begin
            if (val_r == '0) begin
              state_r <= S_SDEND;
            end else if (cnt_dst >= CNT_W'(MAX_EVENTS)) begin
              status_r <= STAT_FULL;
              state_r  <= S_SDEND;
            end else begin
              pins_r[~act_r] <= pins_r[~act_r] | pin_bit;
              cnt_r[~act_r]  <= cnt_dst + 1'b1;
              x_r            <= entry_new;
              p_r            <= cnt_dst;
              state_r        <= S_BUBL;
            end
          end else if (rd_pin_hit) begin
            p_r <= i_r;
            if (val_r == '0) begin
              cnt_r[~act_r]  <= cnt_dst - 1'b1;
              pins_r[~act_r] <= pins_r[~act_r] & ~pin_bit;
              state_r        <= (i_r < cnt_dst - 1'b1) ? S_RMV : S_SDEND;
            end else begin
              x_r     <= entry_new;
              state_r <= S_BUBL;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        // last entry fills the hole of the removed one
        S_RMV: begin
          x_r     <= rd_data;
          state_r <= S_BUBL;
        end
        // move the changed entry to its place, earlier side first
        S_BUBL: begin
          if (bubl_move) begin
            p_r     <= p_dec;
            moved_r <= 1'b1;
          end else begin
            state_r <= moved_r ? S_SDEND : S_BUBR;
          end
        end
        S_BUBR: begin
          if (bubr_move) begin
            p_r <= p_inc;
          end else begin
            state_r <= S_SDEND;
          end
        end
        S_SDEND: begin
          pv_r    <= 1'b1;
          i_r     <= '0;
          state_r <= (act_code_r == ACT_RELEASE) ? S_REL : S_DONE;
        end
        // release turns the pin's active entry into an end entry
        S_REL: begin
          if (i_r == cnt_act) begin
            state_r <= S_DONE;
          end else if (rd_pin_hit) begin
            lvl_r   <= lvl_r & ~pin_bit;
            state_r <= S_DONE;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        // tick: fire due events until the next one lies ahead
        S_TK0: begin
          cur_r   <= ev_word;
          state_r <= S_TK1;
        end
        S_TK1: begin
          tnow_r  <= alu_res[TNOW_W-1:0];
          iter_r  <= '0;
          state_r <= S_TKP;
        end
        S_TKP: begin
          if (entry_pin(cur_r) != END_PIN) begin
            lvl_r  <= lvl_r | (NPINS'(1) << entry_pin(cur_r));
            nidx_r <= nidx_r + 1'b1;
          end else begin
            lvl_r  <= lvl_r & ~pins_r[act_r];
            nidx_r <= '0;
            tnow_r <= '0;
            if (pv_r) begin
              act_r <= ~act_r;
              pv_r  <= 1'b0;
            end
          end
          state_r <= S_TKR;
        end
        S_TKR: begin
          cur_r   <= ev_word;
          state_r <= S_TKM;
        end
        S_TKM: begin
          prod_r  <= alu_res[TNOW_W-1:0];
          state_r <= S_TKC;
        end
        S_TKC: begin
          if (alu_res == '0 && iter_r < ITER_W'(ITER_MAX - 1)) begin
            iter_r  <= iter_r + 1'b1;
            state_r <= S_TKP;
          end else begin
            if (alu_res[ALU_W]) begin
              delay_r <= '0;
            end else if (|alu_res[ALU_W-1:TICK_W]) begin
              delay_r <= '1;
            end else begin
              delay_r <= alu_res[TICK_W-1:0];
            end
            state_r <= S_DONE;
          end
        end
        // load the result once the output register is free
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                <= 1'b1;
            out_data_r.pin_levels      <= lvl_r;
            out_data_r.output_enables  <= en_r;
            out_data_r.next_delay      <= delay_r;
            out_data_r.period_ticks    <= pv_r ? per_r[~act_r] : per_act;
            out_data_r.status          <= status_r;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/elps_checker.sv */
// elps_checker: port-level checks of the pwm scheduler, bound to the top level
// depends on elps_pkg and event_list_pwm_scheduler_unit
module elps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input elps_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input elps_pkg::out_item_t out_data
);
  import elps_pkg::*;

  // a stalled result stays
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // an accepted item keeps the block busy for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer right after the first");

  // only enabled pins can be driven high
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pin_levels & ~out_data.output_enables) == '0)
    else $error("level on a pin that is not enabled");

endmodule

bind event_list_pwm_scheduler_unit elps_checker u_elps_checker (.*);
